[src/fbcr_pkg.sv]
package fbcr_pkg;

    // Register window size in bytes; offsets at or beyond it are rejected.
    localparam int WINDOW_BYTES = 256;

    // Operation codes
    localparam logic [1:0] OP_READ       = 2'd0;
    localparam logic [1:0] OP_WRITE      = 2'd1;
    localparam logic [1:0] OP_FRAME_TICK = 2'd2;
    localparam logic [1:0] OP_INVALIDATE = 2'd3;

    // Register byte offsets
    localparam logic [7:0] OFF_WIDTH     = 8'h00;
    localparam logic [7:0] OFF_HEIGHT    = 8'h04;
    localparam logic [7:0] OFF_INT_STAT  = 8'h08;
    localparam logic [7:0] OFF_INT_EN    = 8'h0c;
    localparam logic [7:0] OFF_BASE      = 8'h10;
    localparam logic [7:0] OFF_ROTATION  = 8'h14;
    localparam logic [7:0] OFF_BLANK     = 8'h18;
    localparam logic [7:0] OFF_WIDTH_MM  = 8'h1c;
    localparam logic [7:0] OFF_HEIGHT_MM = 8'h20;
    localparam logic [7:0] OFF_FORMAT    = 8'h24;

    // Status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_OFF   = 2'd1;
    localparam logic [1:0] ST_ROTATION  = 2'd2;
    localparam logic [1:0] ST_BAD_DEPTH = 2'd3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DPI      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEPTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_GPU = 3'd4;
    localparam int CFG_DATA_W = 13;

    // Interrupt bits
    localparam int IRQ_VSYNC     = 0;
    localparam int IRQ_BASE_DONE = 1;

    // Physical size: floor((254*pix + 5*dpi) / (10*dpi))
    localparam int MM_SCALE     = 254;
    localparam int MM_ROUND     = 5;
    localparam int MM_DEN_SCALE = 10;
    localparam int MM_NUM_W     = 21;
    localparam int MM_DEN_W     = 14;
    localparam int DIV_CNT_W    = $clog2(MM_NUM_W);

    typedef struct packed {
        logic [1:0]  operation;
        logic [7:0]  offset;
        logic [31:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_level;
        logic [1:0]  status_code;
        logic        took_update;
        logic        frame_done;
        logic        blanked;
    } t_out_word;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic start_div;
        logic commit;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic is_mm;
        logic div_done;
        logic slot_free;
    } t_dp_status;

endpackage

[src/fbcr_div.sv]
module fbcr_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [fbcr_pkg::MM_NUM_W-1:0] i_num,
    input  logic [fbcr_pkg::MM_DEN_W-1:0] i_den,
    output logic                          o_done,
    output logic [fbcr_pkg::MM_NUM_W-1:0] o_quo
);
    import fbcr_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [MM_DEN_W-1:0]  r_rem, n_rem;
    logic [MM_DEN_W-1:0]  r_den, n_den;
    logic [MM_NUM_W-1:0]  r_quo, n_quo;
    logic [MM_DEN_W:0]    shifted;
    logic                 fits;

    // One quotient bit per cycle, restoring form.
    assign shifted = {r_rem, r_quo[MM_NUM_W-1]};
    assign fits    = shifted >= {1'b0, r_den};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_den  = r_den;
        n_quo  = r_quo;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_den  = i_den;
            n_quo  = i_num;
        end else if (r_busy) begin
            n_rem = fits ? MM_DEN_W'(shifted - {1'b0, r_den}) : shifted[MM_DEN_W-1:0];
            n_quo = {r_quo[MM_NUM_W-2:0], fits};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == DIV_CNT_W'(MM_NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_den <= n_den;
        r_quo <= n_quo;
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[src/fbcr_ctrl.sv]
module fbcr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  fbcr_pkg::t_dp_status i_status,
    output fbcr_pkg::t_dp_cmd    o_cmd
);
    import fbcr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DECODE = 2'd1;
    localparam logic [1:0] S_DIVIDE = 2'd2;
    localparam logic [1:0] S_COMMIT = 2'd3;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd.capture   = 1'b0;
        o_cmd.start_div = 1'b0;
        o_cmd.commit    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.is_mm) begin
                    o_cmd.start_div = 1'b1;
                    n_state         = S_DIVIDE;
                end else begin
                    n_state = S_COMMIT;
                end
            end
            S_DIVIDE: begin
                if (i_status.div_done) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_status.slot_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = r_state != S_IDLE;

endmodule

[src/fbcr_datapath.sv]
module fbcr_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fbcr_pkg::t_in_word                  i_in_word,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output fbcr_pkg::t_out_word                 o_out_word,
    input  logic                                i_cfg_wr_en,
    input  logic [fbcr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fbcr_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  fbcr_pkg::t_dp_cmd                   i_cmd,
    output fbcr_pkg::t_dp_status                o_status
);
    import fbcr_pkg::*;

    // Configuration
    logic [12:0] r_width, r_height;
    logic [9:0]  r_dpi;
    logic [5:0]  r_depth;
    logic        r_host_gpu;

    // Device state
    logic [1:0]  r_int_stat, n_int_stat;
    logic [1:0]  r_int_en, n_int_en;
    logic [31:0] r_base, n_base;
    logic        r_upd, n_upd;
    logic        r_notify, n_notify;
    logic        r_blank, n_blank;
    logic        r_irq, n_irq;

    t_in_word    r_item;
    t_out_word   r_out, n_out;
    logic        r_out_valid;

    logic                in_window;
    logic                mm_off;
    logic [12:0]         mm_pix;
    logic [MM_NUM_W-1:0] mm_num;
    logic [MM_DEN_W-1:0] mm_den;
    logic                div_done;
    logic [MM_NUM_W-1:0] div_quo;
    logic                do_tick;
    logic [1:0]          hit;

    assign in_window = 32'(r_item.offset) < 32'(WINDOW_BYTES);
    assign mm_off = (r_item.offset == OFF_WIDTH_MM) || (r_item.offset == OFF_HEIGHT_MM);
    assign mm_pix = (r_item.offset == OFF_WIDTH_MM) ? r_width : r_height;
    assign mm_num = MM_NUM_W'(mm_pix) * MM_NUM_W'(MM_SCALE)
                  + MM_NUM_W'(r_dpi) * MM_NUM_W'(MM_ROUND);
    assign mm_den = MM_DEN_W'(r_dpi) * MM_DEN_W'(MM_DEN_SCALE);
    assign hit    = r_int_stat & r_int_en;

    fbcr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.start_div),
        .i_num   (mm_num),
        .i_den   (mm_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign o_status.is_mm     = (r_item.operation == OP_READ) && in_window && mm_off
                              && (r_dpi != '0);
    assign o_status.div_done  = div_done;
    assign o_status.slot_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_int_stat = r_int_stat;
        n_int_en   = r_int_en;
        n_base     = r_base;
        n_upd      = r_upd;
        n_notify   = r_notify;
        n_blank    = r_blank;
        n_irq      = r_irq;
        do_tick    = 1'b0;
        n_out      = '0;

        case (r_item.operation)
            OP_READ: begin
                if (!in_window) begin
                    n_out.status_code = ST_BAD_OFF;
                end else begin
                    case (r_item.offset)
                        OFF_WIDTH:  n_out.read_data = 32'(r_width);
                        OFF_HEIGHT: n_out.read_data = 32'(r_height);
                        OFF_INT_STAT: begin
                            n_out.read_data = 32'(hit);
                            if (hit != '0) begin
                                n_int_stat = r_int_stat & ~hit;
                                n_irq      = 1'b0;
                            end
                        end
                        OFF_WIDTH_MM, OFF_HEIGHT_MM: begin
                            if (r_dpi != '0) begin
                                n_out.read_data = 32'(div_quo);
                            end
                        end
                        OFF_FORMAT: begin
                            if (r_depth == 6'd32 || r_depth == 6'd24) begin
                                n_out.read_data = 32'd2;
                            end else if (r_depth == 6'd16) begin
                                n_out.read_data = 32'd4;
                            end else begin
                                n_out.status_code = ST_BAD_DEPTH;
                            end
                        end
                        default: n_out.status_code = ST_BAD_OFF;
                    endcase
                end
            end
            OP_WRITE: begin
                if (!in_window) begin
                    n_out.status_code = ST_BAD_OFF;
                end else begin
                    case (r_item.offset)
                        OFF_INT_EN: begin
                            n_int_en = r_item.write_data[1:0];
                            n_irq    = (r_int_stat & r_item.write_data[1:0]) != '0;
                        end
                        OFF_BASE: begin
                            n_base                    = r_item.write_data;
                            n_int_stat[IRQ_BASE_DONE] = 1'b0;
                            n_upd                     = 1'b1;
                            n_notify                  = 1'b1;
                            do_tick                   = !r_host_gpu;
                        end
                        OFF_ROTATION: n_out.status_code = ST_ROTATION;
                        OFF_BLANK: begin
                            n_blank = r_item.write_data[0];
                            n_upd   = 1'b1;
                        end
                        default: n_out.status_code = ST_BAD_OFF;
                    endcase
                end
            end
            OP_FRAME_TICK: do_tick = 1'b1;
            OP_INVALIDATE: n_upd   = 1'b1;
            default: n_upd = r_upd;
        endcase

        // Frame tick: vsync, then consume a pending update.
        if (do_tick && n_base != '0) begin
            n_out.frame_done = 1'b1;
            if (n_int_en[IRQ_VSYNC] && !n_int_stat[IRQ_VSYNC]) begin
                n_int_stat[IRQ_VSYNC] = 1'b1;
                n_irq                 = 1'b1;
            end
            if (n_upd) begin
                n_out.took_update = 1'b1;
                if (n_notify) begin
                    n_int_stat[IRQ_BASE_DONE] = 1'b1;
                    if (n_int_en[IRQ_BASE_DONE]) begin
                        n_irq = 1'b1;
                    end
                end
                n_notify = 1'b0;
                n_upd    = 1'b0;
            end
            n_out.blanked = n_blank;
        end

        // A base write outside host-GPU mode resyncs the line to the enabled status.
        if (r_item.operation == OP_WRITE && in_window && r_item.offset == OFF_BASE
                && !r_host_gpu) begin
            n_irq = (n_int_stat & n_int_en) != '0;
        end

        n_out.irq_level = n_irq;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= 13'd320;
            r_height    <= 13'd480;
            r_dpi       <= 10'd165;
            r_depth     <= 6'd32;
            r_host_gpu  <= 1'b0;
            r_int_stat  <= '0;
            r_int_en    <= '0;
            r_base      <= '0;
            r_upd       <= 1'b0;
            r_notify    <= 1'b0;
            r_blank     <= 1'b0;
            r_irq       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_WIDTH:    r_width    <= i_cfg_wdata[12:0];
                    CFG_HEIGHT:   r_height   <= i_cfg_wdata[12:0];
                    CFG_DPI:      r_dpi      <= i_cfg_wdata[9:0];
                    CFG_DEPTH:    r_depth    <= i_cfg_wdata[5:0];
                    CFG_HOST_GPU: r_host_gpu <= i_cfg_wdata[0];
                    default:      r_host_gpu <= r_host_gpu;
                endcase
            end
            if (i_cmd.commit) begin
                r_int_stat  <= n_int_stat;
                r_int_en    <= n_int_en;
                r_base      <= n_base;
                r_upd       <= n_upd;
                r_notify    <= n_notify;
                r_blank     <= n_blank;
                r_irq       <= n_irq;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (i_cmd.capture) begin
            r_item <= i_in_word;
        end
        if (i_cmd.commit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

[src/framebuffer_control_registers.sv]
// Channel   | Direction | Handshake                     | Word
// ----------+-----------+-------------------------------+-------------------------
// request   | in        | i_in_valid / o_in_stall       | i_in_word  (t_in_word)
// response  | out       | o_out_valid / i_out_stall     | o_out_word (t_out_word)
// config    | in        | i_cfg_wr_en, i_cfg_index      | i_cfg_wdata
//
// One request word at a time. After the accepting edge the word passes the decode
// and commit states; the response register loads on commit, then the next word is taken.
// A width/height-in-mm read adds the divide state: 21 divider steps, then done.
// The response register decouples the sides: a new request is accepted while
// an earlier response is still stalled; only its commit waits for it.
// Reset is synchronous and active low; it restores geometry, clears device state and response valid.
module framebuffer_control_registers (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fbcr_pkg::t_in_word              i_in_word,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fbcr_pkg::t_out_word             o_out_word,
    input  logic                            i_cfg_wr_en,
    input  logic [fbcr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [fbcr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import fbcr_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    // Sequence each word: capture, decode, optional divide, commit.
    fbcr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Hold configuration, device state, the divider and the response word.
    fbcr_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status)
    );

endmodule

[src/fbcr_checker.sv]
module fbcr_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input fbcr_pkg::t_out_word o_out_word
);
    import fbcr_pkg::*;

    // A stalled response word holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("response word changed while stalled");

    // Only one request in flight: stall right after acceptance.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request accepted while another is in flight");

    // Any error status carries zero read data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.status_code != ST_OK |-> o_out_word.read_data == '0)
        else $error("error response with nonzero read data");

    // Update and blank flags only come with a frame that ran.
    a_frame_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.frame_done
            |-> !o_out_word.took_update && !o_out_word.blanked)
        else $error("frame flags without a frame");

    // Reset empties the response register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid after reset");

endmodule

bind framebuffer_control_registers fbcr_checker u_fbcr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

[tb/sv/framebuffer_control_registers_test.sv]
module framebuffer_control_registers_test;

    import fbcr_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 30;     // longer than the slowest word (mm read)
    localparam int ITEMS_PER_PHASE = 215;
    localparam int PHASES          = 9;
    localparam int LONG_HOLD       = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int TIMEOUT         = 2000000;

    // Reported pixel formats
    localparam logic [31:0] FMT_RGBX_8888 = 32'd2;
    localparam logic [31:0] FMT_RGB_565   = 32'd4;

    localparam logic [7:0] MAP_OFFSETS [10] = '{OFF_WIDTH, OFF_HEIGHT, OFF_INT_STAT,
        OFF_INT_EN, OFF_BASE, OFF_ROTATION, OFF_BLANK, OFF_WIDTH_MM, OFF_HEIGHT_MM,
        OFF_FORMAT};
    localparam logic [7:0] WRITE_OFFSETS [4] = '{OFF_INT_EN, OFF_BASE, OFF_ROTATION,
        OFF_BLANK};

    typedef struct packed {
        t_in_word  word;
        logic      typed;     // result below is known up front
        t_out_word result;
    } stim_row_t;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    t_in_word              i_in_word   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out_word             o_out_word;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    framebuffer_control_registers dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    // Shadow copy of the geometry registers, updated as they are written.
    logic [12:0] cfg_width    = 13'd320;
    logic [12:0] cfg_height   = 13'd480;
    logic [9:0]  cfg_dpi      = 10'd165;
    logic [5:0]  cfg_depth    = 6'd32;
    logic        cfg_host_gpu = 1'b0;

    // Shadow copy of the interrupt and update state.
    logic [1:0]  irq_status     = '0;
    logic [1:0]  irq_enable     = '0;
    logic [31:0] fb_base        = '0;
    logic        update_pending = 1'b0;
    logic        notify_pending = 1'b0;
    logic        blank_on       = 1'b0;
    logic        irq_line       = 1'b0;

    t_out_word pending_responses [$];
    stim_row_t directed_rows [$];
    int        mismatches     = 0;
    int        send_idle_pct  = 0;
    int        recv_stall_pct = 0;
    int        holds_asked    = 0;
    int        holds_served   = 0;

    // Physical size in mm, rounded to nearest: floor((254*pix + 5*dpi) / (10*dpi)).
    function automatic logic [31:0] size_in_mm(logic [12:0] pixels, logic [9:0] dpi);
        longint unsigned num;
        longint unsigned den;
        logic [31:0]     mm;
        mm = '0;
        if (dpi != 0) begin
            num = MM_SCALE * longint'(pixels) + MM_ROUND * longint'(dpi);
            den = MM_DEN_SCALE * longint'(dpi);
            mm  = 32'(num / den);
        end
        return mm;
    endfunction

    // One display refresh: raise vsync, consume a pending update and, if the
    // base write asked for it, raise base-update-done. Does nothing on a zero base.
    function automatic void run_frame(output logic full, output logic done,
                                      output logic blk);
        full = 1'b0;
        done = 1'b0;
        blk  = 1'b0;
        if (fb_base != '0) begin
            done = 1'b1;
            if (irq_enable[IRQ_VSYNC] && !irq_status[IRQ_VSYNC]) begin
                irq_status[IRQ_VSYNC] = 1'b1;
                irq_line = 1'b1;
            end
            if (update_pending) begin
                full = 1'b1;
                if (notify_pending) begin
                    irq_status[IRQ_BASE_DONE] = 1'b1;
                    if (irq_enable[IRQ_BASE_DONE])
                        irq_line = 1'b1;
                end
                notify_pending = 1'b0;
                update_pending = 1'b0;
            end
            blk = blank_on;
        end
    endfunction

    // Advance the shadow state by one request word and return its response.
    function automatic t_out_word predict_response(t_in_word w);
        t_out_word  r;
        logic [1:0] hit;
        r = '0;
        case (w.operation)
            OP_READ: begin
                case (w.offset)
                    OFF_WIDTH:     r.read_data = 32'(cfg_width);
                    OFF_HEIGHT:    r.read_data = 32'(cfg_height);
                    OFF_INT_STAT: begin
                        // Clear only the enabled bits that are set; drop the line.
                        hit = irq_status & irq_enable;
                        r.read_data = 32'(hit);
                        if (hit != '0) begin
                            irq_status = irq_status & ~hit;
                            irq_line   = 1'b0;
                        end
                    end
                    OFF_WIDTH_MM:  r.read_data = size_in_mm(cfg_width, cfg_dpi);
                    OFF_HEIGHT_MM: r.read_data = size_in_mm(cfg_height, cfg_dpi);
                    OFF_FORMAT: begin
                        if (cfg_depth == 6'd32 || cfg_depth == 6'd24)
                            r.read_data = FMT_RGBX_8888;
                        else if (cfg_depth == 6'd16)
                            r.read_data = FMT_RGB_565;
                        else
                            r.status_code = ST_BAD_DEPTH;
                    end
                    default:       r.status_code = ST_BAD_OFF;
                endcase
            end
            OP_WRITE: begin
                case (w.offset)
                    OFF_INT_EN: begin
                        irq_enable = w.write_data[1:0];
                        irq_line   = |(irq_status & irq_enable);
                    end
                    OFF_BASE: begin
                        fb_base = w.write_data;
                        irq_status[IRQ_BASE_DONE] = 1'b0;
                        update_pending = 1'b1;
                        notify_pending = 1'b1;
                        // Host-GPU mode leaves both the redraw and the line alone.
                        if (!cfg_host_gpu) begin
                            run_frame(r.took_update, r.frame_done, r.blanked);
                            irq_line = |(irq_status & irq_enable);
                        end
                    end
                    OFF_ROTATION:  r.status_code = ST_ROTATION;
                    OFF_BLANK: begin
                        blank_on       = w.write_data[0];
                        update_pending = 1'b1;
                    end
                    default:       r.status_code = ST_BAD_OFF;
                endcase
            end
            OP_FRAME_TICK: run_frame(r.took_update, r.frame_done, r.blanked);
            default:       update_pending = 1'b1;
        endcase
        r.irq_level = irq_line;
        return r;
    endfunction

    function automatic stim_row_t checked_row(logic [1:0] op, logic [7:0] off,
                                              logic [31:0] data);
        stim_row_t r;
        r = '0;
        r.word.operation  = op;
        r.word.offset     = off;
        r.word.write_data = data;
        return r;
    endfunction

    // Rows whose response is obvious: no frame runs and the line stays low.
    function automatic stim_row_t known_row(logic [1:0] op, logic [7:0] off,
                                            logic [31:0] data, logic [31:0] rd,
                                            logic [1:0] st);
        stim_row_t r;
        r = checked_row(op, off, data);
        r.typed = 1'b1;
        r.result.read_data   = rd;
        r.result.status_code = st;
        return r;
    endfunction

    // Mostly well-formed register traffic and refresh events; the rest is noise
    // with any operation at any offset.
    function automatic t_in_word random_word();
        t_in_word    w;
        int unsigned pick;
        pick = $urandom_range(99);
        w.operation  = 2'($urandom_range(3));
        w.offset     = 8'($urandom_range(255));
        w.write_data = $urandom();
        if (pick < 30) begin
            w.operation = OP_READ;
            w.offset    = MAP_OFFSETS[$urandom_range(9)];
        end else if (pick < 52) begin
            w.operation = OP_WRITE;
            if ($urandom_range(4) == 0)
                w.offset = MAP_OFFSETS[$urandom_range(9)];
            else
                w.offset = WRITE_OFFSETS[$urandom_range(3)];
            // A zero base disables the refresh; hit it often.
            if (w.offset == OFF_BASE && $urandom_range(3) == 0)
                w.write_data = '0;
        end else if (pick < 75) begin
            w.operation = OP_FRAME_TICK;
        end else if (pick < 85) begin
            w.operation = OP_INVALIDATE;
        end
        return w;
    endfunction

    // Offer one word, idling at random first; hold it until accepted, then
    // queue its response. Called and returns at a rising edge.
    task automatic offer_word(stim_row_t s);
        t_out_word predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= s.word;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        predicted = predict_response(s.word);
        pending_responses.push_back(s.typed ? s.result : predicted);
    endtask

    // Drop valid and wait until every response is back and the block is idle.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_responses.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all five geometry registers back to back; unused high data bits
    // carry noise, which the block must drop.
    task automatic apply_config(logic [12:0] w, logic [12:0] h, logic [9:0] dpi,
                                logic [5:0] depth, logic gpu);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_WIDTH;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_index <= CFG_HEIGHT;
        i_cfg_wdata <= h;
        @(posedge i_clk);
        i_cfg_index <= CFG_DPI;
        i_cfg_wdata <= {3'($urandom), dpi};
        @(posedge i_clk);
        i_cfg_index <= CFG_DEPTH;
        i_cfg_wdata <= {7'($urandom), depth};
        @(posedge i_clk);
        i_cfg_index <= CFG_HOST_GPU;
        i_cfg_wdata <= {12'($urandom), gpu};
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        cfg_width    = w;
        cfg_height   = h;
        cfg_dpi      = dpi;
        cfg_depth    = depth;
        cfg_host_gpu = gpu;
    endtask

    // Receiver: stall at random, or hold off for a long stretch on request so
    // that the block backs up into its request side.
    initial begin : response_sink
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holds_served != holds_asked) begin
                hold_left = LONG_HOLD;
                holds_served++;
            end
            if (hold_left != 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Compare every accepted response with the oldest prediction.
    always @(posedge i_clk) begin : response_check
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_responses.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("response word %h with nothing outstanding", o_out_word);
            end else begin
                want = pending_responses.pop_front();
                if (o_out_word.read_data   !== want.read_data   ||
                    o_out_word.irq_level   !== want.irq_level   ||
                    o_out_word.status_code !== want.status_code ||
                    o_out_word.took_update !== want.took_update ||
                    o_out_word.frame_done  !== want.frame_done  ||
                    o_out_word.blanked     !== want.blanked) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("mismatch: want rd=%h irq=%b st=%0d upd=%b done=%b blk=%b",
                                 want.read_data, want.irq_level, want.status_code,
                                 want.took_update, want.frame_done, want.blanked);
                        $display("          got  rd=%h irq=%b st=%0d upd=%b done=%b blk=%b",
                                 o_out_word.read_data, o_out_word.irq_level,
                                 o_out_word.status_code, o_out_word.took_update,
                                 o_out_word.frame_done, o_out_word.blanked);
                    end
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT);
        $display("[framebuffer_control_registers] ERROR");
        $finish;
    end

    initial begin : stimulus
        int phase;
        // Directed walk from reset defaults (320x480, 165 dpi, depth 32).
        directed_rows.push_back(known_row(OP_READ, OFF_WIDTH, '0, 32'd320, ST_OK));
        directed_rows.push_back(known_row(OP_READ, OFF_HEIGHT, '1, 32'd480, ST_OK));
        directed_rows.push_back(known_row(OP_READ, OFF_FORMAT, '0, FMT_RGBX_8888, ST_OK));
        directed_rows.push_back(checked_row(OP_READ, OFF_WIDTH_MM, '0));
        directed_rows.push_back(known_row(OP_READ, OFF_INT_STAT, '0, '0, ST_OK));
        directed_rows.push_back(known_row(OP_READ, 8'h02, '0, '0, ST_BAD_OFF));
        directed_rows.push_back(known_row(OP_READ, 8'hfc, '1, '0, ST_BAD_OFF));
        directed_rows.push_back(known_row(OP_WRITE, OFF_WIDTH, '1, '0, ST_BAD_OFF));
        directed_rows.push_back(known_row(OP_WRITE, OFF_ROTATION, '1, '0, ST_ROTATION));
        // Refresh and base writes with a zero base run no frame.
        directed_rows.push_back(known_row(OP_FRAME_TICK, 8'hff, '1, '0, ST_OK));
        directed_rows.push_back(known_row(OP_WRITE, OFF_INT_EN, '1, '0, ST_OK));
        directed_rows.push_back(known_row(OP_WRITE, OFF_BASE, '0, '0, ST_OK));
        directed_rows.push_back(known_row(OP_FRAME_TICK, '0, '0, '0, ST_OK));
        // Real base: immediate refresh, vsync and base-done both raised.
        directed_rows.push_back(checked_row(OP_WRITE, OFF_BASE, '1));
        directed_rows.push_back(checked_row(OP_READ, OFF_INT_STAT, '0));
        directed_rows.push_back(checked_row(OP_WRITE, OFF_BLANK, 32'h1));
        directed_rows.push_back(checked_row(OP_FRAME_TICK, '0, '0));
        directed_rows.push_back(checked_row(OP_INVALIDATE, 8'haa, 32'h5555_5555));
        directed_rows.push_back(checked_row(OP_FRAME_TICK, '0, '0));
        // Status read with nothing enabled clears nothing.
        directed_rows.push_back(checked_row(OP_WRITE, OFF_INT_EN, '0));
        directed_rows.push_back(checked_row(OP_READ, OFF_INT_STAT, '0));
        directed_rows.push_back(checked_row(OP_WRITE, OFF_INT_EN, 32'h1));
        directed_rows.push_back(checked_row(OP_READ, OFF_INT_STAT, '0));
        directed_rows.push_back(checked_row(OP_WRITE, OFF_BLANK, 32'hffff_fffe));
        directed_rows.push_back(checked_row(OP_WRITE, 8'h0d, '1));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 12;
        recv_stall_pct = 78;
        foreach (directed_rows[k])
            offer_word(directed_rows[k]);

        for (phase = 0; phase < PHASES; phase++) begin
            settle();
            case (phase)
                0: apply_config(13'd320, 13'd480, 10'd165, 6'd32, 1'b0);
                1: apply_config(13'h1fff, 13'h1fff, 10'h3ff, 6'd16, 1'b0);
                2: apply_config(13'd1, 13'd1, 10'd1, 6'd24, 1'b1);
                // Zero density and zero depth.
                3: apply_config('0, '0, '0, '0, 1'b0);
                4: apply_config(13'h1fff, 13'd1, 10'd1, 6'h3f, 1'b1);
                default: apply_config(13'($urandom_range(8191)), 13'($urandom_range(8191)),
                                      10'($urandom_range(1023)),
                                      ($urandom_range(1) == 0) ? 6'd16 << $urandom_range(1)
                                                               : 6'($urandom_range(63)),
                                      1'($urandom_range(1)));
            endcase
            // Sender idles lightly against a busy receiver, then the reverse,
            // then both run flat out.
            if (phase < 3) begin
                send_idle_pct  = 12;
                recv_stall_pct = 78;
            end else if (phase < 6) begin
                send_idle_pct  = 78;
                recv_stall_pct = 12;
            end else begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            if (phase == 0 || phase == 6)
                holds_asked++;
            repeat (ITEMS_PER_PHASE)
                offer_word('{word: random_word(), typed: 1'b0, result: '0});
        end

        settle();
        if (mismatches == 0)
            $display("[framebuffer_control_registers] OK");
        else
            $display("[framebuffer_control_registers] ERROR");
        $finish;
    end

endmodule
